// File: src/sbf_pkg.sv
package sbf_pkg;

    localparam int CHANNELS     = 2;
    localparam int SAMPLE_WIDTH = 24;
    localparam int COEF_WIDTH   = 32;
    localparam int STATE_BITS   = 32;
    localparam int COEF_FRAC    = COEF_WIDTH - 4;
    localparam int NUM_COEFS    = 5;
    localparam int INDEX_WIDTH  = $clog2(NUM_COEFS);
    localparam int PROD_WIDTH   = COEF_WIDTH + STATE_BITS;
    localparam int TERM_WIDTH   = PROD_WIDTH - COEF_FRAC;
    localparam int ACC_WIDTH    = TERM_WIDTH + 2;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [COEF_WIDTH-1:0]   t_coef;
    typedef logic signed [STATE_BITS-1:0]   t_state;
    typedef logic signed [PROD_WIDTH-1:0]   t_prod;
    typedef logic signed [TERM_WIDTH-1:0]   t_term;
    typedef logic signed [ACC_WIDTH-1:0]    t_acc;

    localparam t_coef  COEF_ONE   = t_coef'(1) <<< COEF_FRAC;
    localparam t_prod  ROUND_HALF = t_prod'(1) <<< (COEF_FRAC - 1);
    localparam t_state STATE_MAX  = {1'b0, {(STATE_BITS-1){1'b1}}};
    localparam t_state STATE_MIN  = {1'b1, {(STATE_BITS-1){1'b0}}};
    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef enum logic [INDEX_WIDTH-1:0] {
        REG_B0 = 0,
        REG_B1 = 1,
        REG_B2 = 2,
        REG_A1 = 3,
        REG_A2 = 4
    } t_reg_idx;

    typedef struct packed {
        t_coef b0;
        t_coef b1;
        t_coef b2;
        t_coef a1;
        t_coef a2;
    } t_coefs;

    typedef struct packed {
        logic    start;
        t_sample x;
    } t_lane_ctrl;

    typedef struct packed {
        logic   done;
        t_state y;
    } t_lane_stat;

    typedef struct packed {
        logic load;
        logic zero;
    } t_merge_ctrl;

    typedef enum logic [2:0] {
        L_IDLE,
        L_B0,
        L_Y,
        L_A1,
        L_B2,
        L_A2,
        L_FIN
    } t_lane_state;

    typedef enum logic [1:0] {
        T_IDLE,
        T_RUN,
        T_DONE
    } t_top_state;

    // product rounded to the operand's fraction bits, ties towards plus infinity
    function automatic t_term round_term(input t_prod p);
        t_prod t;
        t = p + ROUND_HALF;
        return t[PROD_WIDTH-1:COEF_FRAC];
    endfunction

    function automatic t_state sat_state(input t_acc v);
        logic [ACC_WIDTH-STATE_BITS:0] hi;
        hi = v[ACC_WIDTH-1:STATE_BITS-1];
        if ((&hi) || (~|hi)) begin
            return v[STATE_BITS-1:0];
        end else if (v[ACC_WIDTH-1]) begin
            return STATE_MIN;
        end else begin
            return STATE_MAX;
        end
    endfunction

    function automatic t_sample sat_sample(input t_state v);
        logic [STATE_BITS-SAMPLE_WIDTH:0] hi;
        hi = v[STATE_BITS-1:SAMPLE_WIDTH-1];
        if ((&hi) || (~|hi)) begin
            return v[SAMPLE_WIDTH-1:0];
        end else if (v[STATE_BITS-1]) begin
            return SAMPLE_MIN;
        end else begin
            return SAMPLE_MAX;
        end
    endfunction

endpackage

// File: src/sbf_if.sv
interface sbf_in_if;
    logic                   valid;
    logic                   ready;
    sbf_pkg::t_sample       left_sample;
    sbf_pkg::t_sample       right_sample;
    logic                   input_present;

    modport source (output valid, output left_sample, output right_sample,
                    output input_present, input ready);
    modport sink   (input valid, input left_sample, input right_sample,
                    input input_present, output ready);
endinterface

interface sbf_out_if;
    logic                   valid;
    logic                   ready;
    sbf_pkg::t_sample       left_result;
    sbf_pkg::t_sample       right_result;

    modport source (output valid, output left_result, output right_result, input ready);
    modport sink   (input valid, input left_result, input right_result, output ready);
endinterface

interface sbf_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [sbf_pkg::INDEX_WIDTH-1:0]    index;
    sbf_pkg::t_coef                     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/sbf_lane.sv
module sbf_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sbf_pkg::t_lane_ctrl i_ctrl,
    input  sbf_pkg::t_coefs     i_coef,
    output sbf_pkg::t_lane_stat o_stat
);

    sbf_pkg::t_lane_state r_state;
    sbf_pkg::t_lane_state n_state;

    sbf_pkg::t_state r_x;
    sbf_pkg::t_state r_y;
    sbf_pkg::t_state r_d1;
    sbf_pkg::t_state r_d2;
    sbf_pkg::t_prod  r_prod;
    sbf_pkg::t_acc   r_acc;

    sbf_pkg::t_coef  mul_coef;
    sbf_pkg::t_state mul_val;
    sbf_pkg::t_prod  prod;
    sbf_pkg::t_acc   term;
    logic            done;

    always_comb begin
        n_state = r_state;
        case (r_state)
            sbf_pkg::L_IDLE: begin
                if (i_ctrl.start) begin
                    n_state = sbf_pkg::L_B0;
                end
            end
            sbf_pkg::L_B0:  n_state = sbf_pkg::L_Y;
            sbf_pkg::L_Y:   n_state = sbf_pkg::L_A1;
            sbf_pkg::L_A1:  n_state = sbf_pkg::L_B2;
            sbf_pkg::L_B2:  n_state = sbf_pkg::L_A2;
            sbf_pkg::L_A2:  n_state = sbf_pkg::L_FIN;
            sbf_pkg::L_FIN: n_state = sbf_pkg::L_IDLE;
            default:        n_state = sbf_pkg::L_IDLE;
        endcase
    end

    // one shared multiplier, operands picked by step
    always_comb begin
        mul_coef = i_coef.b0;
        mul_val  = r_x;
        done     = 1'b0;
        case (r_state)
            sbf_pkg::L_B0: begin
                mul_coef = i_coef.b0;
                mul_val  = r_x;
            end
            sbf_pkg::L_Y: begin
                mul_coef = i_coef.b1;
                mul_val  = r_x;
            end
            sbf_pkg::L_A1: begin
                mul_coef = i_coef.a1;
                mul_val  = r_y;
            end
            sbf_pkg::L_B2: begin
                mul_coef = i_coef.b2;
                mul_val  = r_x;
            end
            sbf_pkg::L_A2: begin
                mul_coef = i_coef.a2;
                mul_val  = r_y;
            end
            sbf_pkg::L_FIN: begin
                done = 1'b1;
            end
            default: begin
                mul_coef = i_coef.b0;
                mul_val  = r_x;
            end
        endcase
    end

    assign prod = mul_coef * mul_val;
    assign term = sbf_pkg::t_acc'(sbf_pkg::round_term(r_prod));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbf_pkg::L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else begin
            case (r_state)
                sbf_pkg::L_A2:  r_d1 <= sbf_pkg::sat_state(r_acc);
                sbf_pkg::L_FIN: r_d2 <= sbf_pkg::sat_state(r_acc - term);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            sbf_pkg::L_IDLE: begin
                if (i_ctrl.start) begin
                    r_x <= sbf_pkg::t_state'(i_ctrl.x);
                end
            end
            sbf_pkg::L_B0: begin
                r_prod <= prod;
            end
            sbf_pkg::L_Y: begin
                r_y    <= sbf_pkg::sat_state(term + sbf_pkg::t_acc'(r_d1));
                r_prod <= prod;
            end
            sbf_pkg::L_A1: begin
                // b1*x plus old second delay
                r_acc  <= term + sbf_pkg::t_acc'(r_d2);
                r_prod <= prod;
            end
            sbf_pkg::L_B2: begin
                r_acc  <= r_acc - term;
                r_prod <= prod;
            end
            sbf_pkg::L_A2: begin
                r_acc  <= term;
                r_prod <= prod;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.done = done;
    assign o_stat.y    = r_y;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |-> r_state == sbf_pkg::L_IDLE)
        else $error("lane started while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> !done)
        else $error("lane done held longer than one cycle");

    a_d1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != sbf_pkg::L_A2 |=> $stable(r_d1))
        else $error("first delay changed outside its update step");

    a_d2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != sbf_pkg::L_FIN |=> $stable(r_d2))
        else $error("second delay changed outside its update step");
`endif

endmodule

// File: src/sbf_merge.sv
module sbf_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sbf_pkg::t_merge_ctrl i_ctrl,
    input  sbf_pkg::t_state      i_y [sbf_pkg::CHANNELS],
    output logic                 o_free,
    sbf_out_if.source            o_out
);

    logic             r_valid;
    sbf_pkg::t_sample r_left;
    sbf_pkg::t_sample r_right;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            if (i_ctrl.zero) begin
                r_left  <= '0;
                r_right <= '0;
            end else begin
                r_left  <= sbf_pkg::sat_sample(i_y[0]);
                r_right <= sbf_pkg::sat_sample(i_y[1]);
            end
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.left_result  = r_left;
    assign o_out.right_result = r_right;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.load |-> o_free)
        else $error("result loaded over an untaken beat");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.load |=> o_out.valid)
        else $error("loaded result not presented");

    a_zero_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.load && i_ctrl.zero |=>
            o_out.left_result == '0 && o_out.right_result == '0)
        else $error("absent frame gave a non-zero result");
`endif

endmodule

// File: src/stereo_biquad_filter_unit.sv
// channel   direction  beat contents
// i_in      in         left_sample, right_sample, input_present
// i_cfg     in         index (0 b0, 1 b1, 2 b2, 3 a1, 4 a2), data
// o_out     out        left_result, right_result
//
// a present frame shows its result after the lanes and the output load: one lane per channel,
// each running six steps through its single 32x32 multiplier, then the output load
// an absent frame skips the lanes, loads a zero result and leaves the delay words alone
// the output load waits until the output register is free, and the next frame is accepted
// only after the previous result has been loaded, so frames are taken one at a time
// one finished beat may wait in the output register while the next frame runs
// synchronous reset: b0 = 1.0, other coefficients and all delay words zero
module stereo_biquad_filter_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sbf_in_if.sink    i_in,
    sbf_cfg_if.sink   i_cfg,
    sbf_out_if.source o_out
);

    sbf_pkg::t_coefs      r_coef;
    sbf_pkg::t_top_state  r_state;
    sbf_pkg::t_top_state  n_state;
    logic                 r_absent;

    logic                 in_ready;
    logic                 lane_start;
    logic                 merge_free;
    sbf_pkg::t_merge_ctrl merge_ctrl;
    sbf_pkg::t_sample     lane_x [sbf_pkg::CHANNELS];
    sbf_pkg::t_lane_stat  lane_stat [sbf_pkg::CHANNELS];
    sbf_pkg::t_state      lane_y [sbf_pkg::CHANNELS];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.b0 <= sbf_pkg::COEF_ONE;
            r_coef.b1 <= '0;
            r_coef.b2 <= '0;
            r_coef.a1 <= '0;
            r_coef.a2 <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                sbf_pkg::REG_B0: r_coef.b0 <= i_cfg.data;
                sbf_pkg::REG_B1: r_coef.b1 <= i_cfg.data;
                sbf_pkg::REG_B2: r_coef.b2 <= i_cfg.data;
                sbf_pkg::REG_A1: r_coef.a1 <= i_cfg.data;
                sbf_pkg::REG_A2: r_coef.a2 <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sbf_pkg::T_IDLE: begin
                if (i_in.valid) begin
                    n_state = i_in.input_present ? sbf_pkg::T_RUN : sbf_pkg::T_DONE;
                end
            end
            sbf_pkg::T_RUN: begin
                if (lane_stat[0].done) begin
                    n_state = sbf_pkg::T_DONE;
                end
            end
            sbf_pkg::T_DONE: begin
                if (merge_free) begin
                    n_state = sbf_pkg::T_IDLE;
                end
            end
            default: n_state = sbf_pkg::T_IDLE;
        endcase
    end

    always_comb begin
        in_ready        = 1'b0;
        lane_start      = 1'b0;
        merge_ctrl.load = 1'b0;
        merge_ctrl.zero = r_absent;
        case (r_state)
            sbf_pkg::T_IDLE: begin
                in_ready   = 1'b1;
                lane_start = i_in.valid && i_in.input_present;
            end
            sbf_pkg::T_DONE: begin
                merge_ctrl.load = merge_free;
            end
            default: begin
            end
        endcase
    end

    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sbf_pkg::T_IDLE;
            r_absent <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_in.valid && in_ready) begin
                r_absent <= !i_in.input_present;
            end
        end
    end

    assign lane_x[0] = i_in.left_sample;
    assign lane_x[1] = i_in.right_sample;

    for (genvar g = 0; g < sbf_pkg::CHANNELS; g++) begin : g_lane
        sbf_pkg::t_lane_ctrl ctrl;

        assign ctrl.start = lane_start;
        assign ctrl.x     = lane_x[g];
        assign lane_y[g]  = lane_stat[g].y;

        sbf_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl),
            .i_coef  (r_coef),
            .o_stat  (lane_stat[g])
        );
    end

    sbf_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (merge_ctrl),
        .i_y     (lane_y),
        .o_free  (merge_free),
        .o_out   (o_out)
    );

endmodule

// File: bench/tb_stereo_biquad_filter_unit.sv
`timescale 1ns / 1ps

module tb_stereo_biquad_filter_unit;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 80;
    localparam int RUN_LIMIT_NS  = 5_000_000;
    localparam int CH_LEFT       = 0;
    localparam int CH_RIGHT      = 1;

    localparam sbf_pkg::t_coef COEF_MAX = {1'b0, {(sbf_pkg::COEF_WIDTH-1){1'b1}}};
    localparam sbf_pkg::t_coef COEF_MIN = {1'b1, {(sbf_pkg::COEF_WIDTH-1){1'b0}}};

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_SINK, IDLE_BOTH} t_idle_mode;

    typedef struct {
        sbf_pkg::t_sample left_res;
        sbf_pkg::t_sample right_res;
    } t_frame_out;

    logic clk;
    logic rst_n;

    sbf_in_if  in_ch ();
    sbf_cfg_if cfg_ch ();
    sbf_out_if out_ch ();

    stereo_biquad_filter_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // filter model state
    sbf_pkg::t_coef  coef_bank [sbf_pkg::NUM_COEFS];
    sbf_pkg::t_state z1_word   [sbf_pkg::CHANNELS];
    sbf_pkg::t_state z2_word   [sbf_pkg::CHANNELS];

    t_frame_out due_frames [$];

    int error_count;
    int frames_sent;
    int silent_frames;
    int beats_checked;
    int coef_writes;
    int send_idle_pct;
    int sink_stall_pct;
    int hold_left;
    bit hold_request;

    initial begin
        clk = 1'b0;
        forever begin
            #CLK_HALF clk = ~clk;
        end
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("[stereo_biquad_filter_unit] ERROR");
        $finish;
    end

    // coefficient times operand, rounded half up to the operand's fraction bits
    function automatic longint scaled(input sbf_pkg::t_coef c, input longint v);
        longint p;
        p = longint'(c) * v + (longint'(1) <<< (sbf_pkg::COEF_FRAC - 1));
        return p >>> sbf_pkg::COEF_FRAC;
    endfunction

    function automatic longint clamp(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    function automatic t_frame_out filter_frame(input sbf_pkg::t_sample l,
                                                input sbf_pkg::t_sample r,
                                                input logic present);
        t_frame_out       res;
        sbf_pkg::t_sample xs [sbf_pkg::CHANNELS];
        sbf_pkg::t_sample ys [sbf_pkg::CHANNELS];
        longint           x;
        longint           y;
        longint           d1;
        longint           d2;
        res.left_res  = '0;
        res.right_res = '0;
        // silent frame: zero out, delay words held
        if (!present) begin
            return res;
        end
        xs[CH_LEFT]  = l;
        xs[CH_RIGHT] = r;
        for (int c = 0; c < sbf_pkg::CHANNELS; c++) begin
            x  = longint'(xs[c]);
            y  = clamp(scaled(coef_bank[sbf_pkg::REG_B0], x) + longint'(z1_word[c]),
                       sbf_pkg::STATE_BITS);
            d1 = scaled(coef_bank[sbf_pkg::REG_B1], x) - scaled(coef_bank[sbf_pkg::REG_A1], y)
                 + longint'(z2_word[c]);
            d2 = scaled(coef_bank[sbf_pkg::REG_B2], x) - scaled(coef_bank[sbf_pkg::REG_A2], y);
            z1_word[c] = sbf_pkg::t_state'(clamp(d1, sbf_pkg::STATE_BITS));
            z2_word[c] = sbf_pkg::t_state'(clamp(d2, sbf_pkg::STATE_BITS));
            ys[c] = sbf_pkg::t_sample'(clamp(y, sbf_pkg::SAMPLE_WIDTH));
        end
        res.left_res  = ys[CH_LEFT];
        res.right_res = ys[CH_RIGHT];
        return res;
    endfunction

    function automatic sbf_pkg::t_coef milli_coef(input int m);
        return sbf_pkg::t_coef'((longint'(m) <<< sbf_pkg::COEF_FRAC) / 1000);
    endfunction

    // full scale most of the time, quieter samples otherwise
    function automatic sbf_pkg::t_sample any_sample();
        sbf_pkg::t_sample s;
        s = sbf_pkg::t_sample'($urandom);
        if ($urandom_range(3) == 0) begin
            s = s >>> $urandom_range(16);
        end
        return s;
    endfunction

    // result checker
    always @(posedge clk) begin
        t_frame_out want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            beats_checked++;
            if (due_frames.size() == 0) begin
                error_count++;
                $display("%0t: result beat with nothing expected, got left %0d right %0d",
                         $time, out_ch.left_result, out_ch.right_result);
            end else begin
                want = due_frames.pop_front();
                if (out_ch.left_result !== want.left_res) begin
                    error_count++;
                    $display("%0t: left_result expected %0d, got %0d",
                             $time, want.left_res, out_ch.left_result);
                end
                if (out_ch.right_result !== want.right_res) begin
                    error_count++;
                    $display("%0t: right_result expected %0d, got %0d",
                             $time, want.right_res, out_ch.right_result);
                end
            end
        end
    end

    // output side back-pressure, with an occasional long hold-off
    always @(negedge clk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic set_idling(input t_idle_mode m);
        case (m)
            IDLE_NONE: begin
                send_idle_pct = 0;
                sink_stall_pct = 0;
            end
            IDLE_SEND: begin
                send_idle_pct = 46;
                sink_stall_pct = 0;
            end
            IDLE_SINK: begin
                send_idle_pct = 0;
                sink_stall_pct = 46;
            end
            default: begin
                send_idle_pct = 24;
                sink_stall_pct = 24;
            end
        endcase
    endtask

    // entered and left at a falling edge; valid stays up for the next call
    task automatic send_frame(input sbf_pkg::t_sample l, input sbf_pkg::t_sample r,
                              input logic present);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.left_sample   <= l;
        in_ch.right_sample  <= r;
        in_ch.input_present <= present;
        do begin
            @(posedge clk);
        end while (!in_ch.ready);
        due_frames.push_back(filter_frame(l, r, present));
        frames_sent++;
        if (!present) begin
            silent_frames++;
        end
        @(negedge clk);
    endtask

    // drop valid, wait for every beat to come out, then let the lanes settle
    task automatic drain();
        int w;
        in_ch.valid <= 1'b0;
        for (w = 0; w < DRAIN_LIMIT && due_frames.size() != 0; w++) begin
            @(posedge clk);
        end
        if (due_frames.size() != 0) begin
            error_count++;
            $display("%0t: %0d result beats never arrived", $time, due_frames.size());
            due_frames.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [sbf_pkg::INDEX_WIDTH-1:0] idx,
                             input sbf_pkg::t_coef val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do begin
            @(posedge clk);
        end while (!cfg_ch.ready);
        if (idx < sbf_pkg::NUM_COEFS) begin
            coef_bank[idx] = val;
        end
        coef_writes++;
        @(negedge clk);
    endtask

    task automatic program_filter(input sbf_pkg::t_coef b0, input sbf_pkg::t_coef b1,
                                  input sbf_pkg::t_coef b2, input sbf_pkg::t_coef a1,
                                  input sbf_pkg::t_coef a2);
        drain();
        write_reg(sbf_pkg::REG_B0, b0);
        write_reg(sbf_pkg::REG_B1, b1);
        write_reg(sbf_pkg::REG_B2, b2);
        write_reg(sbf_pkg::REG_A1, a1);
        write_reg(sbf_pkg::REG_A2, a2);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // poles kept inside the unit circle so the output does not just pin at the rails
    task automatic program_stable_filter();
        int a2_m;
        int a1_lim;
        int a1_m;
        a2_m = int'($urandom_range(1800)) - 900;
        a1_lim = (1000 + a2_m) * 95 / 100;
        a1_m = int'($urandom_range(2 * a1_lim)) - a1_lim;
        program_filter(milli_coef(int'($urandom_range(4000)) - 2000),
                       milli_coef(int'($urandom_range(4000)) - 2000),
                       milli_coef(int'($urandom_range(4000)) - 2000),
                       milli_coef(a1_m), milli_coef(a2_m));
    endtask

    task automatic run_random_frames(input int count, input int present_pct);
        for (int n = 0; n < count; n++) begin
            send_frame(any_sample(), any_sample(), $urandom_range(99) < present_pct);
        end
    endtask

    task automatic test_reset_passthrough();
        set_idling(IDLE_NONE);
        send_frame(sbf_pkg::SAMPLE_MAX, sbf_pkg::SAMPLE_MIN, 1'b1);
        send_frame(sbf_pkg::SAMPLE_MIN, sbf_pkg::SAMPLE_MAX, 1'b1);
        send_frame('0, -1, 1'b1);
        send_frame(sbf_pkg::SAMPLE_MAX, sbf_pkg::SAMPLE_MAX, 1'b0);
        send_frame(sbf_pkg::SAMPLE_MIN, -1, 1'b0);
        send_frame(sbf_pkg::t_sample'(1), sbf_pkg::t_sample'(-2), 1'b1);
    endtask

    task automatic test_saturation();
        // large gain overflows the result, strong feedback overflows the delay words
        program_filter(COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX);
        repeat (3) send_frame(sbf_pkg::SAMPLE_MAX, sbf_pkg::SAMPLE_MIN, 1'b1);
        repeat (3) send_frame(sbf_pkg::SAMPLE_MIN, sbf_pkg::SAMPLE_MAX, 1'b1);
    endtask

    task automatic test_rounding_ties();
        program_filter(sbf_pkg::COEF_ONE >>> 1, '0, '0, '0, '0);
        // flush the saturated delay words first
        repeat (2) send_frame('0, '0, 1'b1);
        send_frame(sbf_pkg::t_sample'(1), sbf_pkg::t_sample'(-1), 1'b1);
        send_frame(sbf_pkg::t_sample'(3), sbf_pkg::t_sample'(-3), 1'b1);
        send_frame(sbf_pkg::SAMPLE_MAX, sbf_pkg::SAMPLE_MIN, 1'b1);
        send_frame(sbf_pkg::t_sample'(-5), sbf_pkg::t_sample'(5), 1'b1);
        send_frame(sbf_pkg::SAMPLE_MIN, sbf_pkg::t_sample'(7), 1'b1);
    endtask

    task automatic test_unmapped_index();
        drain();
        for (int k = sbf_pkg::NUM_COEFS; k < (1 << sbf_pkg::INDEX_WIDTH); k++) begin
            write_reg(k[sbf_pkg::INDEX_WIDTH-1:0], sbf_pkg::t_coef'($urandom));
        end
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
        send_frame(sbf_pkg::SAMPLE_MAX, sbf_pkg::t_sample'(3), 1'b1);
        send_frame(sbf_pkg::t_sample'(-3), sbf_pkg::SAMPLE_MIN, 1'b1);
        send_frame(any_sample(), any_sample(), 1'b1);
    endtask

    task automatic test_random_filters();
        t_idle_mode modes [4];
        modes = '{IDLE_NONE, IDLE_SEND, IDLE_SINK, IDLE_BOTH};
        foreach (modes[m]) begin
            set_idling(modes[m]);
            repeat (4) begin
                program_stable_filter();
                run_random_frames(64, 85);
            end
        end
    endtask

    task automatic test_extreme_coefs();
        set_idling(IDLE_BOTH);
        program_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        run_random_frames(24, 80);
        program_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        run_random_frames(24, 80);
        program_filter(sbf_pkg::t_coef'($urandom), sbf_pkg::t_coef'($urandom),
                       sbf_pkg::t_coef'($urandom), sbf_pkg::t_coef'($urandom),
                       sbf_pkg::t_coef'($urandom));
        run_random_frames(24, 80);
    endtask

    task automatic test_backpressure();
        set_idling(IDLE_NONE);
        program_stable_filter();
        // sink holds off while frames keep coming, so the input must stall
        hold_request = 1'b1;
        run_random_frames(30, 90);
        // sender pauses until every beat is back
        drain();
        run_random_frames(10, 90);
    endtask

    initial begin
        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.left_sample   = '0;
        in_ch.right_sample  = '0;
        in_ch.input_present = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        out_ch.ready        = 1'b0;
        error_count    = 0;
        frames_sent    = 0;
        silent_frames  = 0;
        beats_checked  = 0;
        coef_writes    = 0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        hold_left      = 0;
        hold_request   = 1'b0;
        coef_bank[sbf_pkg::REG_B0] = sbf_pkg::COEF_ONE;
        coef_bank[sbf_pkg::REG_B1] = '0;
        coef_bank[sbf_pkg::REG_B2] = '0;
        coef_bank[sbf_pkg::REG_A1] = '0;
        coef_bank[sbf_pkg::REG_A2] = '0;
        for (int c = 0; c < sbf_pkg::CHANNELS; c++) begin
            z1_word[c] = '0;
            z2_word[c] = '0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_passthrough();
        test_saturation();
        test_rounding_ties();
        test_unmapped_index();
        test_random_filters();
        test_extreme_coefs();
        test_backpressure();
        drain();

        $display("covered %0d frames (%0d silent) across %0d coefficient writes,",
                 frames_sent, silent_frames, coef_writes);
        $display("checked %0d result beats under idle, stall and hold-off traffic",
                 beats_checked);
        if (error_count == 0) begin
            $display("[stereo_biquad_filter_unit] OK");
        end else begin
            $display("[stereo_biquad_filter_unit] ERROR");
        end
        $finish;
    end

endmodule
